// File: hdl/tipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tipd_pkg
// Shared types, byte constants and character-class helpers for the title
// invalid-pattern detector.
// ----------------------------------------------------------------------------
package tipd_pkg;

  // Rule codes, lowest number has priority.
  typedef enum logic [2:0] {
    RULE_NONE      = 3'd0,
    RULE_COLON     = 3'd1,
    RULE_FORBIDDEN = 3'd2,
    RULE_SENTINEL  = 3'd3,
    RULE_PERCENT   = 3'd4,
    RULE_DOT       = 3'd5
  } rule_e;

  // Sentinel matcher phase.
  typedef enum logic [3:0] {
    SENT_IDLE   = 4'b0001,
    SENT_NUL    = 4'b0010,
    SENT_DIGITS = 4'b0100,
    SENT_TAG    = 4'b1000
  } sent_e;

  // Percent matcher phase.
  typedef enum logic [2:0] {
    PCT_IDLE = 3'b001,
    PCT_ONE  = 3'b010,
    PCT_TWO  = 3'b100
  } pct_e;

  // Dot-segment matcher: segment start, ".", "..", anything else.
  typedef enum logic [3:0] {
    DOTS_START = 4'b0001,
    DOTS_ONE   = 4'b0010,
    DOTS_TWO   = 4'b0100,
    DOTS_OTHER = 4'b1000
  } dots_e;

  // Title-end report from the scanner.
  typedef struct packed {
    logic  done;
    rule_e rule;
  } result_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LE      = 8'h65;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_LH      = 8'h68;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_PIPE    = 8'h7C;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_DEL     = 8'h7F;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LF)) ||
           ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic is_forbidden(input logic [7:0] c);
    return (c == CH_LT) || (c == CH_GT) || (c == CH_LBRACK) || (c == CH_RBRACK) ||
           (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_PIPE) || (c == CH_NL);
  endfunction

  function automatic logic is_tag(input logic [7:0] c);
    return (c == CH_LE) || (c == CH_LH) || (c == CH_BANG) || (c == CH_PLUS) ||
           (c == CH_MINUS);
  endfunction

endpackage

// File: hdl/tipd_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tipd_scan
// Matcher state and single-pass update: one registered word per step.
// ----------------------------------------------------------------------------
module tipd_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic                empty_i,
  output tipd_pkg::result_t   res_o
);

  logic              start_q, start_d;
  tipd_pkg::rule_e   found_q, found_d;
  tipd_pkg::sent_e   sent_q, sent_d, sent_nxt;
  tipd_pkg::pct_e    pct_q, pct_d, pct_nxt;
  tipd_pkg::dots_e   dots_q, dots_d, dots_nxt, dots_end;
  tipd_pkg::rule_e   hit, found_byte, found_end;
  logic              sent_fire, pct_fire, dot_fire, hex, digit;

  always_comb begin
    digit = tipd_pkg::is_digit(byte_i);
    hex   = tipd_pkg::is_hex(byte_i);

    // sentinel: NUL, digits, tag, DEL
    sent_fire = (sent_q == tipd_pkg::SENT_TAG) && (byte_i == tipd_pkg::CH_DEL);
    if (byte_i == tipd_pkg::CH_NUL) begin
      sent_nxt = tipd_pkg::SENT_NUL;
    end else begin
      unique case (sent_q)
        tipd_pkg::SENT_NUL: begin
          sent_nxt = digit ? tipd_pkg::SENT_DIGITS : tipd_pkg::SENT_IDLE;
        end
        tipd_pkg::SENT_DIGITS: begin
          if (digit) begin
            sent_nxt = tipd_pkg::SENT_DIGITS;
          end else if (tipd_pkg::is_tag(byte_i)) begin
            sent_nxt = tipd_pkg::SENT_TAG;
          end else begin
            sent_nxt = tipd_pkg::SENT_IDLE;
          end
        end
        default: sent_nxt = tipd_pkg::SENT_IDLE;
      endcase
    end

    // percent followed by two hex digits
    pct_fire = (pct_q == tipd_pkg::PCT_TWO) && hex;
    if (byte_i == tipd_pkg::CH_PERCENT) begin
      pct_nxt = tipd_pkg::PCT_ONE;
    end else begin
      unique case (pct_q)
        tipd_pkg::PCT_ONE: pct_nxt = hex ? tipd_pkg::PCT_TWO : tipd_pkg::PCT_IDLE;
        default:           pct_nxt = tipd_pkg::PCT_IDLE;
      endcase
    end

    // dot segments
    dot_fire = 1'b0;
    if (byte_i == tipd_pkg::CH_SLASH) begin
      dot_fire = (dots_q == tipd_pkg::DOTS_ONE) || (dots_q == tipd_pkg::DOTS_TWO);
      dots_nxt = tipd_pkg::DOTS_START;
    end else if (byte_i == tipd_pkg::CH_DOT) begin
      unique case (dots_q)
        tipd_pkg::DOTS_START: dots_nxt = tipd_pkg::DOTS_ONE;
        tipd_pkg::DOTS_ONE:   dots_nxt = tipd_pkg::DOTS_TWO;
        default:              dots_nxt = tipd_pkg::DOTS_OTHER;
      endcase
    end else begin
      dots_nxt = tipd_pkg::DOTS_OTHER;
    end

    // lowest rule wins
    if (start_q && (byte_i == tipd_pkg::CH_COLON)) begin
      hit = tipd_pkg::RULE_COLON;
    end else if (tipd_pkg::is_forbidden(byte_i)) begin
      hit = tipd_pkg::RULE_FORBIDDEN;
    end else if (sent_fire) begin
      hit = tipd_pkg::RULE_SENTINEL;
    end else if (pct_fire) begin
      hit = tipd_pkg::RULE_PERCENT;
    end else if (dot_fire) begin
      hit = tipd_pkg::RULE_DOT;
    end else begin
      hit = tipd_pkg::RULE_NONE;
    end

    found_byte = (found_q == tipd_pkg::RULE_NONE) ? hit : found_q;

    // empty word ends the title without a byte
    if (empty_i) begin
      res_o.done = 1'b1;
      dots_end   = dots_q;
      found_end  = found_q;
    end else begin
      res_o.done = last_i;
      dots_end   = dots_nxt;
      found_end  = found_byte;
    end

    if ((found_end == tipd_pkg::RULE_NONE) &&
        ((dots_end == tipd_pkg::DOTS_ONE) || (dots_end == tipd_pkg::DOTS_TWO))) begin
      res_o.rule = tipd_pkg::RULE_DOT;
    end else begin
      res_o.rule = found_end;
    end

    // next state
    if (res_o.done) begin
      start_d = 1'b1;
      found_d = tipd_pkg::RULE_NONE;
      sent_d  = tipd_pkg::SENT_IDLE;
      pct_d   = tipd_pkg::PCT_IDLE;
      dots_d  = tipd_pkg::DOTS_START;
    end else begin
      start_d = 1'b0;
      found_d = found_byte;
      sent_d  = sent_nxt;
      pct_d   = pct_nxt;
      dots_d  = dots_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      found_q <= tipd_pkg::RULE_NONE;
      sent_q  <= tipd_pkg::SENT_IDLE;
      pct_q   <= tipd_pkg::PCT_IDLE;
      dots_q  <= tipd_pkg::DOTS_START;
    end else if (step_i) begin
      start_q <= start_d;
      found_q <= found_d;
      sent_q  <= sent_d;
      pct_q   <= pct_d;
      dots_q  <= dots_d;
    end
  end

endmodule

// File: hdl/title_invalid_pattern_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// title_invalid_pattern_detector_core
// Byte-serial title checker: reports the first forbidden pattern per title.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per title byte:
//   byte_value_i, is_last_i, and empty_title_i for a zero-length title (or
//   to end a title without a further byte). Output channel (out_valid_o /
//   out_stall_i) carries one word per title end: invalid_o and first_rule_o
//   (0 none, 1 colon, 2 forbidden byte, 3 sentinel, 4 percent pair, 5 dot
//   segment). Words that do not end a title produce no output word.
//   A word is taken at an edge where valid is high and stall is low.
//   Throughput: one input word per cycle while in_stall_o is low. The input
//   register feeds the matchers, and the result register holds the title-end
//   word, so an accepted closing word passes both registers before output.
//   While the receiver stalls, the full result register holds; the input
//   register still drains words that do not end a title, and in_stall_o
//   rises only when a title-end word is waiting behind a stalled result.
//   Reset (rst_ni low, asynchronous) empties both registers and puts every
//   matcher back at the start of a title.
// ----------------------------------------------------------------------------
module title_invalid_pattern_detector_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_value_i,
  input  logic       is_last_i,
  input  logic       empty_title_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       invalid_o,
  output logic [2:0] first_rule_o
);

  // input register
  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic              empty_q;

  // result register
  logic              out_valid_q;
  tipd_pkg::rule_e   out_rule_q;

  tipd_pkg::result_t res;
  logic              accept;
  logic              advance;
  logic              out_free;

  // A word in the input register moves on unless it ends a title while
  // the result register is still full and stalled.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (out_free || !res.done);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  tipd_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (byte_q),
    .last_i  (last_q),
    .empty_i (empty_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= byte_value_i;
      last_q  <= is_last_i;
      empty_q <= empty_title_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.done) begin
      out_rule_q <= res.rule;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign invalid_o    = (out_rule_q != tipd_pkg::RULE_NONE);
  assign first_rule_o = out_rule_q;

endmodule

// File: dv/tipd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tipd_checker
// Watches both channels of the title checker, predicts one verdict word per
// title end and compares the output words in order.
// ----------------------------------------------------------------------------
module tipd_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] byte_value_i,
  input  logic       is_last_i,
  input  logic       empty_title_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       invalid_i,
  input  logic [2:0] first_rule_i,
  output int         mismatches_o,
  output int         titles_due_o
);

  typedef struct packed {
    logic            invalid;
    tipd_pkg::rule_e rule;
  } verdict_t;

  verdict_t verdict_q[$];
  int       fails = 0;
  int       due = 0;

  // Scanner state for the title in flight.
  logic            title_start;
  tipd_pkg::rule_e title_rule;
  tipd_pkg::dots_e seg_dots;
  tipd_pkg::sent_e sent_phase;
  tipd_pkg::pct_e  pct_phase;

  assign mismatches_o = fails;
  assign titles_due_o = due;

  function automatic logic dec_char(input logic [7:0] c);
    return (c >= tipd_pkg::CH_0) && (c <= tipd_pkg::CH_9);
  endfunction

  // Folding to lower case maps A-F onto a-f.
  function automatic logic hex_char(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return dec_char(c) || ((folded >= tipd_pkg::CH_LA) && (folded <= tipd_pkg::CH_LF));
  endfunction

  function automatic logic bad_char(input logic [7:0] c);
    case (c)
      tipd_pkg::CH_LT, tipd_pkg::CH_GT, tipd_pkg::CH_LBRACK, tipd_pkg::CH_RBRACK,
      tipd_pkg::CH_LBRACE, tipd_pkg::CH_RBRACE, tipd_pkg::CH_PIPE,
      tipd_pkg::CH_NL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic tag_char(input logic [7:0] c);
    case (c)
      tipd_pkg::CH_LE, tipd_pkg::CH_LH, tipd_pkg::CH_BANG, tipd_pkg::CH_PLUS,
      tipd_pkg::CH_MINUS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void restart_title();
    title_start = 1'b1;
    title_rule  = tipd_pkg::RULE_NONE;
    seg_dots    = tipd_pkg::DOTS_START;
    sent_phase  = tipd_pkg::SENT_IDLE;
    pct_phase   = tipd_pkg::PCT_IDLE;
  endfunction

  // One accepted input word; queues a verdict at a title end.
  function automatic void scan_word(input logic [7:0] c, input logic last, input logic empty);
    tipd_pkg::rule_e hit;
    verdict_t        v;
    hit = tipd_pkg::RULE_NONE;
    if (!empty) begin
      // Checked in priority order, so the lowest completed rule wins.
      if (title_start && (c == tipd_pkg::CH_COLON)) hit = tipd_pkg::RULE_COLON;
      else if (bad_char(c)) hit = tipd_pkg::RULE_FORBIDDEN;
      else if ((sent_phase == tipd_pkg::SENT_TAG) && (c == tipd_pkg::CH_DEL))
        hit = tipd_pkg::RULE_SENTINEL;
      else if ((pct_phase == tipd_pkg::PCT_TWO) && hex_char(c)) hit = tipd_pkg::RULE_PERCENT;
      else if ((c == tipd_pkg::CH_SLASH) &&
               ((seg_dots == tipd_pkg::DOTS_ONE) || (seg_dots == tipd_pkg::DOTS_TWO)))
        hit = tipd_pkg::RULE_DOT;

      if (c == tipd_pkg::CH_NUL) sent_phase = tipd_pkg::SENT_NUL;
      else if (((sent_phase == tipd_pkg::SENT_NUL) || (sent_phase == tipd_pkg::SENT_DIGITS)) &&
               dec_char(c))
        sent_phase = tipd_pkg::SENT_DIGITS;
      else if ((sent_phase == tipd_pkg::SENT_DIGITS) && tag_char(c))
        sent_phase = tipd_pkg::SENT_TAG;
      else sent_phase = tipd_pkg::SENT_IDLE;

      if (c == tipd_pkg::CH_PERCENT) pct_phase = tipd_pkg::PCT_ONE;
      else if ((pct_phase == tipd_pkg::PCT_ONE) && hex_char(c)) pct_phase = tipd_pkg::PCT_TWO;
      else pct_phase = tipd_pkg::PCT_IDLE;

      if (c == tipd_pkg::CH_SLASH) seg_dots = tipd_pkg::DOTS_START;
      else if (c == tipd_pkg::CH_DOT) begin
        case (seg_dots)
          tipd_pkg::DOTS_START: seg_dots = tipd_pkg::DOTS_ONE;
          tipd_pkg::DOTS_ONE:   seg_dots = tipd_pkg::DOTS_TWO;
          default:              seg_dots = tipd_pkg::DOTS_OTHER;
        endcase
      end else seg_dots = tipd_pkg::DOTS_OTHER;

      title_start = 1'b0;
      if (title_rule == tipd_pkg::RULE_NONE) title_rule = hit;
      if (!last) return;
    end
    // Title end: an open "." or ".." segment still counts.
    if ((title_rule == tipd_pkg::RULE_NONE) &&
        ((seg_dots == tipd_pkg::DOTS_ONE) || (seg_dots == tipd_pkg::DOTS_TWO)))
      title_rule = tipd_pkg::RULE_DOT;
    v.invalid = (title_rule != tipd_pkg::RULE_NONE);
    v.rule    = title_rule;
    verdict_q.push_back(v);
    restart_title();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      restart_title();
      verdict_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected word invalid=%0b first_rule=%0d",
                     $realtime, invalid_i, first_rule_i);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if ((invalid_i !== want.invalid) || (first_rule_i !== want.rule)) begin
            if (fails < 10)
              $display("%0t: word mismatch invalid exp %0b got %0b, first_rule exp %0d got %0d",
                       $realtime, want.invalid, invalid_i, want.rule, first_rule_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) scan_word(byte_value_i, is_last_i, empty_title_i);
    end
    due = verdict_q.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives byte-serial titles into the title checker core: a short directed
// set for each rule and corner, then random titles built from pattern
// fragments, with random idle bursts on both channels and one long output
// hold. The checker module predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] byte_value = 8'h00;
  logic       is_last = 1'b0;
  logic       empty_title = 1'b0;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire        invalid;
  wire  [2:0] first_rule;
  int         mismatches;
  int         titles_due;

  // Stimulus controls; rx_bursts and hold_req are shared with the receiver process.
  int   words_sent = 0;
  bit   tx_bursts = 1'b1;
  bit   rx_bursts = 1'b1;
  bit   hold_req = 1'b0;

  // Bytes of the title being built.
  logic [7:0] title_buf[$];

  always #6 clk = ~clk;

  title_invalid_pattern_detector_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .byte_value_i  (byte_value),
    .is_last_i     (is_last),
    .empty_title_i (empty_title),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .invalid_o     (invalid),
    .first_rule_o  (first_rule)
  );

  tipd_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .byte_value_i  (byte_value),
    .is_last_i     (is_last),
    .empty_title_i (empty_title),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .invalid_i     (invalid),
    .first_rule_i  (first_rule),
    .mismatches_o  (mismatches),
    .titles_due_o  (titles_due)
  );

  // Offer one word, changing inputs only at the falling edge. A random gap
  // may come first; the word then stays put until an edge with stall low.
  task automatic send_word(input logic [7:0] b, input logic last, input logic empty);
    @(negedge clk);
    if (tx_bursts && ($urandom_range(0, 4) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    byte_value  <= b;
    is_last     <= last;
    empty_title <= empty;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Send title_buf; close it either with is_last on the final byte or with a
  // trailing empty word (an empty buffer then gives a zero-length title).
  task automatic send_title(input bit close_by_empty);
    foreach (title_buf[k])
      send_word(title_buf[k], !close_by_empty && (k == title_buf.size() - 1), 1'b0);
    if (close_by_empty)
      send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Bytes that some matcher reacts to.
  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 13))
      0:  return tipd_pkg::CH_LT;
      1:  return tipd_pkg::CH_GT;
      2:  return tipd_pkg::CH_LBRACK;
      3:  return tipd_pkg::CH_RBRACK;
      4:  return tipd_pkg::CH_LBRACE;
      5:  return tipd_pkg::CH_RBRACE;
      6:  return tipd_pkg::CH_PIPE;
      7:  return tipd_pkg::CH_NL;
      8:  return tipd_pkg::CH_NUL;
      9:  return tipd_pkg::CH_DEL;
      10: return tipd_pkg::CH_COLON;
      11: return tipd_pkg::CH_PERCENT;
      12: return tipd_pkg::CH_SLASH;
      default: return tipd_pkg::CH_DOT;
    endcase
  endfunction

  // Tag candidates, upper-case E and H included as near misses.
  function automatic logic [7:0] tag_pick();
    case ($urandom_range(0, 6))
      0: return tipd_pkg::CH_LE;
      1: return tipd_pkg::CH_LH;
      2: return tipd_pkg::CH_BANG;
      3: return tipd_pkg::CH_PLUS;
      4: return tipd_pkg::CH_MINUS;
      5: return 8'h45;
      default: return 8'h48;
    endcase
  endfunction

  // Mostly hex digits of either case, sometimes a near miss like g or G.
  function automatic logic [7:0] hex_pick();
    case ($urandom_range(0, 4))
      0: return 8'(tipd_pkg::CH_0 + $urandom_range(0, 9));
      1: return 8'(tipd_pkg::CH_LA + $urandom_range(0, 5));
      2: return 8'(tipd_pkg::CH_UA + $urandom_range(0, 5));
      3: return ($urandom_range(0, 1) != 0) ? 8'h67 : 8'h47;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random title from fragments: whole or broken sentinels, percent pairs,
  // dot segments, colons, noise and plain letters. Mostly short, some long.
  task automatic build_title();
    int goal;
    title_buf.delete();
    goal = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
    while (title_buf.size() < goal) begin
      case ($urandom_range(0, 9))
        0: title_buf.push_back(8'($urandom_range(0, 255)));
        1: title_buf.push_back(odd_byte());
        2: begin
          title_buf.push_back(tipd_pkg::CH_NUL);
          repeat ($urandom_range(0, 3))
            title_buf.push_back(8'(tipd_pkg::CH_0 + $urandom_range(0, 9)));
          if ($urandom_range(0, 4) != 0) title_buf.push_back(tag_pick());
          if ($urandom_range(0, 3) != 0) title_buf.push_back(tipd_pkg::CH_DEL);
        end
        3: begin
          title_buf.push_back(tipd_pkg::CH_PERCENT);
          repeat ($urandom_range(0, 2)) title_buf.push_back(hex_pick());
        end
        4: begin
          if ($urandom_range(0, 1) != 0) title_buf.push_back(tipd_pkg::CH_SLASH);
          repeat ($urandom_range(1, 3)) title_buf.push_back(tipd_pkg::CH_DOT);
          if ($urandom_range(0, 1) != 0) title_buf.push_back(tipd_pkg::CH_SLASH);
        end
        5: title_buf.push_back(tipd_pkg::CH_COLON);
        default: begin
          if ($urandom_range(0, 1) != 0)
            title_buf.push_back(8'(tipd_pkg::CH_LA + $urandom_range(0, 25)));
          else
            title_buf.push_back(8'(tipd_pkg::CH_UA + $urandom_range(0, 25)));
        end
      endcase
    end
  endtask

  // Most titles end on is_last; a few end with an empty word, and a few
  // are zero-length.
  task automatic random_title();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      title_buf.delete();
      send_title(1'b1);
    end else begin
      build_title();
      send_title(pick <= 2);
    end
  endtask

  // Receiver: random stall bursts, or one long hold on request so that the
  // result register fills and the core pushes back on its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_bursts && ($urandom_range(0, 5) == 0)) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int waited;
    waited = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed titles ---
    title_buf = {tipd_pkg::CH_COLON};                          // leading colon
    send_title(1'b0);
    title_buf = {8'hFF, tipd_pkg::CH_GT};                      // top byte, then forbidden
    send_title(1'b0);
    title_buf = {tipd_pkg::CH_NUL, tipd_pkg::CH_0, tipd_pkg::CH_9,
                 tipd_pkg::CH_LE, tipd_pkg::CH_DEL};           // sentinel with two digits
    send_title(1'b0);
    title_buf = {tipd_pkg::CH_PERCENT, tipd_pkg::CH_PERCENT,
                 tipd_pkg::CH_LA, tipd_pkg::CH_UF};            // restart, pair on last byte
    send_title(1'b0);
    title_buf = {tipd_pkg::CH_DOT};                            // lone "." closed by title end
    send_title(1'b0);
    title_buf = {8'h78, tipd_pkg::CH_SLASH,
                 tipd_pkg::CH_DOT, tipd_pkg::CH_DOT};          // ".." closed by empty word
    send_title(1'b1);
    title_buf.delete();                                        // zero-length title
    send_title(1'b1);
    send_word(tipd_pkg::CH_COLON, 1'b1, 1'b1);                 // both marks: byte ignored
    title_buf = {tipd_pkg::CH_NUL, 8'h37, 8'h45,
                 tipd_pkg::CH_DEL};                            // upper-case tag, no sentinel
    send_title(1'b0);

    // --- random titles, idling on both sides ---
    while (words_sent < 250) random_title();

    // Long output hold while the sender keeps offering back to back.
    tx_bursts = 1'b0;
    hold_req  = 1'b1;
    while (words_sent < 330) random_title();

    tx_bursts = 1'b1;
    while (words_sent < 520) random_title();

    // Final stretch at full rate on both channels.
    tx_bursts = 1'b0;
    rx_bursts = 1'b0;
    while (words_sent < 625) random_title();

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding verdicts, then give stray words time to show up.
    while ((titles_due != 0) && (waited < 5000)) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);

    if ((mismatches == 0) && (titles_due == 0)) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
